// File: rtl/tsp_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tsp_pkg
// Shared types and codes of the timer slot pool.
// ----------------------------------------------------------------------------
package tsp_pkg;

	localparam int SLOT_W = 4;
	localparam logic [31:0] REPEAT_BIT = 32'h8000_0000;

	typedef enum logic [1:0] {
		OP_START = 2'd0,
		OP_STOP  = 2'd1,
		OP_FIRE  = 2'd2,
		OP_DRAIN = 2'd3
	} op_t;

	typedef enum logic [2:0] {
		ST_OK      = 3'd0,
		ST_NOFREE  = 3'd1,
		ST_REFUSED = 3'd2,
		ST_BADH    = 3'd3,
		ST_NOTACT  = 3'd4,
		ST_QEMPTY  = 3'd5,
		ST_IGNORED = 3'd6
	} status_t;

	typedef enum logic [1:0] {
		MODE_FREE   = 2'd0,
		MODE_ARMED  = 2'd1,
		MODE_QUEUED = 2'd2
	} mode_t;

	typedef enum logic {
		BK_IDLE  = 1'b0,
		BK_DRAIN = 1'b1
	} bk_state_t;

	// Classified command handed from front to back.
	typedef struct packed {
		op_t                op;
		logic [31:0]        alarm;
		logic               rep;
		logic [31:0]        data;
		logic [31:0]        cb;
		logic [SLOT_W-1:0]  slot;   // 0 when the handle is out of range
		logic [31:0]        tag;    // fire tag, or composed start tag
	} cmd_t;

endpackage

// File: rtl/tsp_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tsp_front
// Classify an input item: decode the handle, compose the start tag.
// ----------------------------------------------------------------------------
module tsp_front #(
	parameter int SLOTS = 12
) (
	input  logic [1:0]     op,
	input  logic [31:0]    alarm_result,
	input  logic           repeat_flag,
	input  logic [31:0]    user_data,
	input  logic [31:0]    callback_id,
	input  logic [31:0]    slot_handle,
	input  logic [31:0]    fire_tag,
	output tsp_pkg::cmd_t  cmd
);

	logic                       hnd_ok;
	tsp_pkg::op_t               op_d;

	assign op_d   = tsp_pkg::op_t'(op);
	assign hnd_ok = !slot_handle[31] && (slot_handle != 32'd0) &&
		(slot_handle <= 32'(SLOTS));

	always_comb begin
		cmd.op    = op_d;
		cmd.alarm = alarm_result;
		cmd.rep   = repeat_flag;
		cmd.data  = user_data;
		cmd.cb    = callback_id;
		cmd.slot  = hnd_ok ? slot_handle[tsp_pkg::SLOT_W-1:0] : '0;
		if (op_d == tsp_pkg::OP_START) begin
			cmd.tag = alarm_result | (repeat_flag ? tsp_pkg::REPEAT_BIT : 32'd0);
		end else begin
			cmd.tag = fire_tag;
		end
	end

endmodule

// File: rtl/tsp_cmd_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tsp_cmd_queue
// Two-entry command queue between front and back.
// ----------------------------------------------------------------------------
module tsp_cmd_queue (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push_valid,
	output logic           push_ready,
	input  tsp_pkg::cmd_t  push_cmd,
	output logic           pop_valid,
	input  logic           pop_ready,
	output tsp_pkg::cmd_t  pop_cmd
);

	tsp_pkg::cmd_t  mem_q [2];
	logic           wp_q, rp_q;
	logic [1:0]     cnt_q;
	logic           do_push, do_pop;

	assign push_ready = (cnt_q != 2'd2);
	assign pop_valid  = (cnt_q != 2'd0);
	assign pop_cmd    = mem_q[rp_q];
	assign do_push    = push_valid && push_ready;
	assign do_pop     = pop_valid && pop_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= 1'b0;
			rp_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (do_push) wp_q <= ~wp_q;
			if (do_pop)  rp_q <= ~rp_q;
			cnt_q <= cnt_q + {1'b0, do_push} - {1'b0, do_pop};
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) mem_q[wp_q] <= push_cmd;
	end

endmodule

// File: rtl/tsp_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tsp_back
// Execute commands against the slot pool, fire queue and result register.
// ----------------------------------------------------------------------------
module tsp_back #(
	parameter int SLOTS = 12
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           cmd_valid,
	output logic           cmd_ready,
	input  tsp_pkg::cmd_t  cmd,
	output logic           out_valid,
	input  logic           out_ready,
	output logic [2:0]     status,
	output logic [3:0]     new_handle,
	output logic [31:0]    alarm_error,
	output logic           clear_alarm,
	output logic           wake,
	output logic [31:0]    fired_tag,
	output logic [31:0]    fired_data,
	output logic [31:0]    fired_callback,
	output logic           last
);

	localparam int CW = $clog2(SLOTS + 1);
	localparam int IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
	localparam int SW = tsp_pkg::SLOT_W;

	logic [31:0]        tag_q  [SLOTS];
	logic [31:0]        data_q [SLOTS];
	logic [31:0]        cb_q   [SLOTS];
	logic               rep_q  [SLOTS];
	tsp_pkg::mode_t     mode_q [SLOTS];
	logic [SW-1:0]      stk_q  [SLOTS];
	logic [SW-1:0]      fifo_q [SLOTS];
	logic [CW-1:0]      free_cnt_q, fifo_cnt_q, dptr_q;

	tsp_pkg::bk_state_t state_q, state_d;
	logic               can_emit, pop, emit_drain;

	logic [SW-1:0]      slot_m1, top_m1, top_slot, dslot, dslot_m1;
	logic [IW-1:0]      cidx, didx;
	logic               dlast;
	logic [SLOTS-1:0]   match, shifted;
	logic [SW-1:0]      fifo_rm [SLOTS];

	assign can_emit = !out_valid || out_ready;
	assign slot_m1  = cmd.slot - SW'(1);
	assign cidx     = slot_m1[IW-1:0];
	assign top_m1   = SW'(free_cnt_q) - SW'(1);
	assign top_slot = stk_q[top_m1[IW-1:0]];
	assign dslot    = fifo_q[dptr_q[IW-1:0]];
	assign dslot_m1 = dslot - SW'(1);
	assign didx     = dslot_m1[IW-1:0];
	assign dlast    = ((dptr_q + CW'(1)) == fifo_cnt_q);

	// Compact the fire queue around the stopped slot.
	always_comb begin
		for (int i = 0; i < SLOTS; i++) begin
			match[i] = (fifo_q[i] == cmd.slot) && (CW'(i) < fifo_cnt_q);
		end
		shifted[0] = match[0];
		for (int i = 1; i < SLOTS; i++) begin
			shifted[i] = shifted[i-1] | match[i];
		end
		for (int i = 0; i < SLOTS; i++) begin
			if (shifted[i] && (i < SLOTS - 1)) begin
				fifo_rm[i] = fifo_q[(i < SLOTS - 1) ? i + 1 : i];
			end else begin
				fifo_rm[i] = fifo_q[i];
			end
		end
	end

	// Next state.
	always_comb begin
		state_d = state_q;
		case (state_q)
			tsp_pkg::BK_IDLE: begin
				if (pop && (cmd.op == tsp_pkg::OP_DRAIN) && (fifo_cnt_q != '0)) begin
					state_d = tsp_pkg::BK_DRAIN;
				end
			end
			tsp_pkg::BK_DRAIN: begin
				if (can_emit && dlast) state_d = tsp_pkg::BK_IDLE;
			end
			default: state_d = tsp_pkg::BK_IDLE;
		endcase
	end

	// Control outputs.
	always_comb begin
		pop        = 1'b0;
		emit_drain = 1'b0;
		case (state_q)
			tsp_pkg::BK_IDLE:  pop        = cmd_valid && can_emit;
			tsp_pkg::BK_DRAIN: emit_drain = can_emit;
			default: ;
		endcase
	end

	assign cmd_ready = pop;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= tsp_pkg::BK_IDLE;
			out_valid  <= 1'b0;
			free_cnt_q <= CW'(SLOTS);
			fifo_cnt_q <= '0;
			dptr_q     <= '0;
			for (int i = 0; i < SLOTS; i++) begin
				mode_q[i] <= tsp_pkg::MODE_FREE;
				tag_q[i]  <= '0;
				stk_q[i]  <= SW'(SLOTS - i);
			end
		end else begin
			state_q <= state_d;
			if (out_ready) out_valid <= 1'b0;
			if (pop) begin
				case (cmd.op)
					tsp_pkg::OP_START: begin
						out_valid <= 1'b1;
						if ((free_cnt_q != '0) && !cmd.alarm[31]) begin
							free_cnt_q   <= free_cnt_q - CW'(1);
							tag_q[IW'(top_slot - SW'(1))]  <= cmd.tag;
							mode_q[IW'(top_slot - SW'(1))] <= tsp_pkg::MODE_ARMED;
						end
					end
					tsp_pkg::OP_STOP: begin
						out_valid <= 1'b1;
						if ((cmd.slot != '0) && (mode_q[cidx] != tsp_pkg::MODE_FREE)) begin
							if (mode_q[cidx] == tsp_pkg::MODE_QUEUED) begin
								for (int i = 0; i < SLOTS; i++) fifo_q[i] <= fifo_rm[i];
								fifo_cnt_q <= fifo_cnt_q - CW'(1);
							end
							mode_q[cidx] <= tsp_pkg::MODE_FREE;
							tag_q[cidx]  <= '0;
							if (free_cnt_q < CW'(SLOTS)) begin
								stk_q[free_cnt_q[IW-1:0]] <= cmd.slot;
								free_cnt_q <= free_cnt_q + CW'(1);
							end
						end
					end
					tsp_pkg::OP_FIRE: begin
						out_valid <= 1'b1;
						if ((cmd.slot != '0) && (mode_q[cidx] == tsp_pkg::MODE_ARMED) &&
							(tag_q[cidx] == cmd.tag) && (fifo_cnt_q < CW'(SLOTS))) begin
							fifo_q[fifo_cnt_q[IW-1:0]] <= cmd.slot;
							fifo_cnt_q   <= fifo_cnt_q + CW'(1);
							mode_q[cidx] <= tsp_pkg::MODE_QUEUED;
						end
					end
					tsp_pkg::OP_DRAIN: begin
						if (fifo_cnt_q == '0) out_valid <= 1'b1;
						dptr_q <= '0;
					end
					default: ;
				endcase
			end
			if (emit_drain) begin
				out_valid <= 1'b1;
				dptr_q    <= dptr_q + CW'(1);
				if (dlast) fifo_cnt_q <= '0;
				if (rep_q[didx]) begin
					mode_q[didx] <= tsp_pkg::MODE_ARMED;
				end else begin
					mode_q[didx] <= tsp_pkg::MODE_FREE;
					tag_q[didx]  <= '0;
					if (free_cnt_q < CW'(SLOTS)) begin
						stk_q[free_cnt_q[IW-1:0]] <= dslot;
						free_cnt_q <= free_cnt_q + CW'(1);
					end
				end
			end
		end
	end

	// Slot payload and result register: no reset needed.
	always_ff @(posedge clk) begin
		if (pop) begin
			status         <= tsp_pkg::ST_OK;
			new_handle     <= '0;
			alarm_error    <= '0;
			clear_alarm    <= 1'b0;
			wake           <= 1'b0;
			fired_tag      <= '0;
			fired_data     <= '0;
			fired_callback <= '0;
			last           <= 1'b1;
			case (cmd.op)
				tsp_pkg::OP_START: begin
					if (free_cnt_q == '0) begin
						status <= tsp_pkg::ST_NOFREE;
					end else if (cmd.alarm[31]) begin
						status      <= tsp_pkg::ST_REFUSED;
						alarm_error <= cmd.alarm;
					end else begin
						new_handle                     <= top_slot;
						data_q[IW'(top_slot - SW'(1))] <= cmd.data;
						cb_q[IW'(top_slot - SW'(1))]   <= cmd.cb;
						rep_q[IW'(top_slot - SW'(1))]  <= cmd.rep;
					end
				end
				tsp_pkg::OP_STOP: begin
					if (cmd.slot == '0) begin
						status <= tsp_pkg::ST_BADH;
					end else if (mode_q[cidx] == tsp_pkg::MODE_FREE) begin
						status <= tsp_pkg::ST_NOTACT;
					end else begin
						clear_alarm <= (mode_q[cidx] == tsp_pkg::MODE_ARMED);
					end
				end
				tsp_pkg::OP_FIRE: begin
					if ((cmd.slot != '0) && (mode_q[cidx] == tsp_pkg::MODE_ARMED) &&
						(tag_q[cidx] == cmd.tag) && (fifo_cnt_q < CW'(SLOTS))) begin
						wake <= 1'b1;
					end else begin
						status <= tsp_pkg::ST_IGNORED;
					end
				end
				tsp_pkg::OP_DRAIN: status <= tsp_pkg::ST_QEMPTY;
				default: ;
			endcase
		end
		if (emit_drain) begin
			status         <= tsp_pkg::ST_OK;
			new_handle     <= '0;
			alarm_error    <= '0;
			clear_alarm    <= 1'b0;
			wake           <= 1'b0;
			fired_tag      <= tag_q[didx];
			fired_data     <= data_q[didx];
			fired_callback <= cb_q[didx];
			last           <= dlast;
		end
	end

	a_free_bound: assert property (@(posedge clk) disable iff (!arst_n)
		free_cnt_q <= CW'(SLOTS))
		else $error("free count above pool size");
	a_pool_sum: assert property (@(posedge clk) disable iff (!arst_n)
		({1'b0, free_cnt_q} + {1'b0, fifo_cnt_q}) <= (CW + 1)'(SLOTS))
		else $error("free plus queued slots exceed pool");
	a_drain_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == tsp_pkg::BK_DRAIN) |-> (dptr_q < fifo_cnt_q))
		else $error("drain pointer past queue end");
	a_drain_end: assert property (@(posedge clk) disable iff (!arst_n)
		(emit_drain && dlast) |=> (state_q == tsp_pkg::BK_IDLE && fifo_cnt_q == '0))
		else $error("drain did not finish on last entry");

endmodule

// File: rtl/timer_slot_pool_with_fire_queue_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// timer_slot_pool_with_fire_queue_core
// Timer slot allocator with a FIFO of fired slots.
// ----------------------------------------------------------------------------
//  channel | handshake            | payload
//  --------+----------------------+------------------------------------------
//  in      | in_valid / in_ready  | op, alarm_result, repeat_flag, user_data,
//          |                      | callback_id, slot_handle, fire_tag
//  out     | out_valid / out_ready| status, new_handle, alarm_error,
//          |                      | clear_alarm, wake, fired_*, last
//
// Start, stop and fire give one result each; the command queue absorbs a
// second item meanwhile. Drain gives one result per cycle unless the output
// stalls, one per queued slot, walking the fire queue in order. Reset is
// asynchronous and needs no clearing pass. A stalled output holds the back
// end; the front keeps taking items until the two-entry queue fills.
// ----------------------------------------------------------------------------
module timer_slot_pool_with_fire_queue_core #(
	parameter int SLOTS = 12
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [1:0]  op,
	input  logic [31:0] alarm_result,
	input  logic        repeat_flag,
	input  logic [31:0] user_data,
	input  logic [31:0] callback_id,
	input  logic [31:0] slot_handle,
	input  logic [31:0] fire_tag,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [2:0]  status,
	output logic [3:0]  new_handle,
	output logic [31:0] alarm_error,
	output logic        clear_alarm,
	output logic        wake,
	output logic [31:0] fired_tag,
	output logic [31:0] fired_data,
	output logic [31:0] fired_callback,
	output logic        last
);

	tsp_pkg::cmd_t  front_cmd, back_cmd;
	logic           q_valid, q_ready;

	// Classify the incoming item.
	tsp_front #(.SLOTS(SLOTS)) u_front (
		.op           (op),
		.alarm_result (alarm_result),
		.repeat_flag  (repeat_flag),
		.user_data    (user_data),
		.callback_id  (callback_id),
		.slot_handle  (slot_handle),
		.fire_tag     (fire_tag),
		.cmd          (front_cmd)
	);

	// Decouple acceptance from execution.
	tsp_cmd_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (in_valid),
		.push_ready (in_ready),
		.push_cmd   (front_cmd),
		.pop_valid  (q_valid),
		.pop_ready  (q_ready),
		.pop_cmd    (back_cmd)
	);

	// Execute against the pool and drive the result register.
	tsp_back #(.SLOTS(SLOTS)) u_back (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd_valid      (q_valid),
		.cmd_ready      (q_ready),
		.cmd            (back_cmd),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.status         (status),
		.new_handle     (new_handle),
		.alarm_error    (alarm_error),
		.clear_alarm    (clear_alarm),
		.wake           (wake),
		.fired_tag      (fired_tag),
		.fired_data     (fired_data),
		.fired_callback (fired_callback),
		.last           (last)
	);

endmodule
